FILE: design/sccb_pkg.sv
package sccb_pkg;

	localparam int unsigned BITS_PER_BYTE = 8;
	localparam int unsigned QUEUE_DEPTH   = 2;
	localparam int unsigned WAIT_W        = 16;

	localparam logic [WAIT_W-1:0] LONG_WAIT_RST  = 16'd500;
	localparam logic [WAIT_W-1:0] SHORT_WAIT_RST = 16'd100;

	localparam logic [2:0] REQ_TICK  = 3'd0;
	localparam logic [2:0] REQ_START = 3'd1;
	localparam logic [2:0] REQ_STOP  = 3'd2;
	localparam logic [2:0] REQ_WRITE = 3'd3;
	localparam logic [2:0] REQ_READ  = 3'd4;
	localparam logic [2:0] REQ_NACK  = 3'd5;

	localparam logic CFG_LONG_WAIT  = 1'b0;
	localparam logic CFG_SHORT_WAIT = 1'b1;

	typedef enum logic [2:0] {
		KIND_TICK,
		KIND_START,
		KIND_STOP,
		KIND_WRITE,
		KIND_READ,
		KIND_NACK
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] tx_byte;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_level;
		logic       sda_drive;
		logic       done_res;
		logic       ack_ok;
		logic [7:0] rx_byte;
		logic       status;
	} result_t;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'd0,
		PH_ST_D1   = 5'd1,
		PH_ST_C1   = 5'd2,
		PH_ST_D0   = 5'd3,
		PH_ST_C0   = 5'd4,
		PH_SP_LOW  = 5'd5,
		PH_SP_C1   = 5'd6,
		PH_SP_D1   = 5'd7,
		PH_WR_BIT  = 5'd8,
		PH_WR_CH   = 5'd9,
		PH_WR_CL   = 5'd10,
		PH_WR_GAP  = 5'd11,
		PH_WR_REL  = 5'd12,
		PH_WR_ACKH = 5'd13,
		PH_WR_ACKS = 5'd14,
		PH_RD_REL  = 5'd15,
		PH_RD_PRE  = 5'd16,
		PH_RD_CH   = 5'd17,
		PH_RD_SAMP = 5'd18,
		PH_NA_D1   = 5'd19,
		PH_NA_CH   = 5'd20,
		PH_NA_CL   = 5'd21
	} phase_t;

endpackage

FILE: design/sccb_front.sv
module sccb_front import sccb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] req_type,
	input  logic [7:0] tx_byte,
	input  logic       sda_in,
	output logic       q_valid,
	output item_t      q_item,
	input  logic       q_pop
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	kind_t             kind;
	logic              push;

	// unused request codes count as ticks
	always_comb begin
		unique case (req_type)
			REQ_START: kind = KIND_START;
			REQ_STOP:  kind = KIND_STOP;
			REQ_WRITE: kind = KIND_WRITE;
			REQ_READ:  kind = KIND_READ;
			REQ_NACK:  kind = KIND_NACK;
			default:   kind = KIND_TICK;
		endcase
	end

	assign in_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{kind: kind, tx_byte: tx_byte, sda_in: sda_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (q_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/sccb_seq.sv
module sccb_seq import sccb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [WAIT_W-1:0] cfg_data,
	input  logic              q_valid,
	input  item_t             q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output result_t           res
);

	logic [WAIT_W-1:0] long_wait_q, short_wait_q;

	phase_t            phase_q, n_phase;
	logic [3:0]        bit_q, n_bit;
	logic [WAIT_W-1:0] wait_q, n_wait, dec_wait, ent_wait;
	logic [7:0]        shift_q, n_shift;
	logic              ack_q, n_ack;
	logic              clk_q, n_clk;
	logic              dout_q, n_dout;
	logic              den_q, n_den;

	logic              out_valid_q;
	result_t           res_q, n_res;

	logic              do_enter;
	phase_t            ent_ph;
	logic [2:0]        bit_idx;

	assign q_pop     = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_wait_q  <= LONG_WAIT_RST;
			short_wait_q <= SHORT_WAIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LONG_WAIT:  long_wait_q  <= cfg_data;
				CFG_SHORT_WAIT: short_wait_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_comb begin
		n_phase  = phase_q;
		n_bit    = bit_q;
		n_wait   = wait_q;
		n_shift  = shift_q;
		n_ack    = ack_q;
		n_clk    = clk_q;
		n_dout   = dout_q;
		n_den    = den_q;
		do_enter = 1'b0;
		ent_ph   = PH_IDLE;
		ent_wait = long_wait_q;
		bit_idx  = '0;
		dec_wait = (wait_q != '0) ? wait_q - 1'b1 : '0;
		n_res    = '0;

		if (q_item.kind != KIND_TICK) begin
			if (phase_q != PH_IDLE) begin
				n_res.status = 1'b1;
			end else begin
				n_bit    = '0;
				do_enter = 1'b1;
				unique case (q_item.kind)
					KIND_START: ent_ph = PH_ST_D1;
					KIND_STOP:  ent_ph = PH_SP_LOW;
					KIND_WRITE: begin
						n_shift = q_item.tx_byte;
						n_ack   = 1'b0;
						ent_ph  = PH_WR_BIT;
					end
					KIND_READ: begin
						n_shift = '0;
						ent_ph  = PH_RD_REL;
					end
					default:    ent_ph = PH_NA_D1;
				endcase
			end
		end else if (phase_q != PH_IDLE) begin
			n_wait = dec_wait;
			if (dec_wait == '0) begin
				unique case (phase_q)
					PH_ST_C0, PH_SP_D1, PH_NA_CL: begin
						n_phase        = PH_IDLE;
						n_res.done_res = 1'b1;
					end
					PH_WR_CL: begin
						n_bit    = bit_q + 1'b1;
						do_enter = 1'b1;
						ent_ph   = (n_bit < 4'(BITS_PER_BYTE)) ? PH_WR_BIT : PH_WR_GAP;
					end
					PH_WR_ACKS: begin
						n_den          = 1'b1;
						n_phase        = PH_IDLE;
						n_res.done_res = 1'b1;
						n_res.ack_ok   = ack_q;
					end
					PH_RD_SAMP: begin
						n_bit = bit_q + 1'b1;
						if (n_bit < 4'(BITS_PER_BYTE)) begin
							do_enter = 1'b1;
							ent_ph   = PH_RD_PRE;
						end else begin
							n_phase        = PH_IDLE;
							n_res.done_res = 1'b1;
							n_res.rx_byte  = shift_q;
						end
					end
					default: begin
						do_enter = 1'b1;
						ent_ph   = phase_t'(phase_q + 5'd1);
					end
				endcase
			end
		end

		// drive the pins of the phase being entered and load its wait
		if (do_enter) begin
			n_phase = ent_ph;
			bit_idx = 3'(BITS_PER_BYTE - 1) - n_bit[2:0];
			unique case (ent_ph)
				PH_ST_D1, PH_NA_D1: begin
					n_dout = 1'b1;
					n_den  = 1'b1;
				end
				PH_ST_C1, PH_SP_C1, PH_WR_CH, PH_RD_CH, PH_NA_CH: n_clk = 1'b1;
				PH_ST_D0: n_dout = 1'b0;
				PH_ST_C0, PH_WR_CL, PH_NA_CL: n_clk = 1'b0;
				PH_SP_LOW: begin
					n_clk  = 1'b0;
					n_dout = 1'b0;
					n_den  = 1'b1;
				end
				PH_SP_D1: n_dout = 1'b1;
				PH_WR_BIT: begin
					n_dout = n_shift[bit_idx];
					n_den  = 1'b1;
				end
				PH_WR_GAP: ent_wait = short_wait_q;
				PH_WR_REL, PH_RD_REL: n_den = 1'b0;
				PH_WR_ACKH: begin
					n_clk    = 1'b1;
					ent_wait = short_wait_q;
				end
				PH_WR_ACKS: begin
					n_ack = !q_item.sda_in;
					n_clk = 1'b0;
				end
				PH_RD_SAMP: begin
					n_shift = {n_shift[6:0], q_item.sda_in};
					n_clk   = 1'b0;
				end
				default: ;
			endcase
			n_wait = (ent_wait == '0) ? WAIT_W'(1) : ent_wait;
		end

		n_res.scl       = n_clk;
		n_res.sda_level = n_dout;
		n_res.sda_drive = n_den;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= '0;
			wait_q  <= '0;
			shift_q <= '0;
			ack_q   <= 1'b0;
			clk_q   <= 1'b1;
			dout_q  <= 1'b1;
			den_q   <= 1'b1;
		end else if (q_pop) begin
			phase_q <= n_phase;
			bit_q   <= n_bit;
			wait_q  <= n_wait;
			shift_q <= n_shift;
			ack_q   <= n_ack;
			clk_q   <= n_clk;
			dout_q  <= n_dout;
			den_q   <= n_den;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= n_res;
		end
	end

endmodule

FILE: design/sccb_bus_master.sv
// A request accepted at the input is written into the request queue, and its result is
// loaded into the output register when the sequencer retires it from the queue.
// Throughput: one request per cycle; the sequencer retires a queued request
// every cycle the output register is free or being emptied.
// Reset: arst_n clears queue and sequencer, sequencer bus lines idle high and driven
// (the result register itself is not reset), waits return to 500 and 100 ticks.
module sccb_bus_master import sccb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [WAIT_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        req_type,
	input  logic [7:0]        tx_byte,
	input  logic              sda_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              scl,
	output logic              sda_level,
	output logic              sda_drive,
	output logic              done_res,
	output logic              ack_ok,
	output logic [7:0]        rx_byte,
	output logic              status
);

	logic    q_valid;
	logic    q_pop;
	item_t   q_item;
	result_t res;

	sccb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.tx_byte  (tx_byte),
		.sda_in   (sda_in),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	sccb_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign scl       = res.scl;
	assign sda_level = res.sda_level;
	assign sda_drive = res.sda_drive;
	assign done_res  = res.done_res;
	assign ack_ok    = res.ack_ok;
	assign rx_byte   = res.rx_byte;
	assign status    = res.status;

endmodule
